[rtl/kart_pkg.sv]
// ----------------------------------------------------------------------------
// kart_pkg: key auto-repeat tracker package
// Payload types, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package kart_pkg;

    localparam int KEY_W   = 8;
    localparam int CFG_W   = 7;
    localparam int CNT_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RST   = 7'd20;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 7'd5;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             key_down;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic             held;
        logic             just_pressed;
        logic             just_released;
        logic             repeat_fire;
    } t_out_item;

endpackage

[rtl/key_auto_repeat_tracker.sv]
// ----------------------------------------------------------------------------
// key_auto_repeat_tracker: per-key typematic auto-repeat tracker
// Keeps a hold counter per key, updates it from one frame sample and reports
// pressed, newly pressed, released and repeat flags for that key.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in  (key_index, key_down)
//  out       output     o_out_valid / i_out_ready  o_out (key_id, flags)
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  An item passes a memory read, an update and write back, and, when the count
//  is past the first delay, 8 steps of the shared shift and subtract remainder
//  unit against the period, then the output load; only then is a new one taken.
//  After reset a clearing pass writes zero to all KEY_COUNT counters, one per
//  cycle; no input transfer is taken until it ends. Configuration is always
//  taken. A stalled output holds the block in its final state.
// ----------------------------------------------------------------------------
module key_auto_repeat_tracker #(
    parameter int KEY_COUNT = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  kart_pkg::t_in_item                     i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output kart_pkg::t_out_item                    o_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [kart_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [kart_pkg::CFG_W-1:0]             i_cfg_data
);

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CW = kart_pkg::CNT_W;
    localparam int FW = kart_pkg::CFG_W;
    localparam int DW = 8;
    localparam int SW = 3;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [CW-1:0]   r_mem [KEY_COUNT];

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic [FW-1:0]   r_first;
    logic [FW-1:0]   r_period;
    logic [AW-1:0]   r_addr;
    logic [kart_pkg::KEY_W-1:0] r_key;
    logic            r_down;
    logic            r_in_range;
    logic [CW-1:0]   r_rd;
    logic            r_held, r_jp, r_jr, r_fire, r_need_div;
    logic [DW-1:0]   r_dvd;
    logic [FW-1:0]   r_rem;
    logic [SW-1:0]   r_div_cnt;
    logic            r_out_valid;
    kart_pkg::t_out_item r_out;

    logic            w_in_xfer;
    logic [AW-1:0]   w_addr;
    logic [FW-1:0]   w_period;
    logic signed [CW:0] w_old;
    logic signed [CW:0] w_inc;
    logic signed [CW:0] w_new;
    logic signed [CW:0] w_limit;
    logic [DW-1:0]   w_rem_sh;
    logic [FW-1:0]   w_rem_nx;
    logic            w_out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_addr      = AW'(i_in.key_index);
    assign w_period    = (r_period == '0) ? FW'(1) : r_period;
    assign w_out_load  = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_old   = {r_rd[CW-1], r_rd};
        w_inc   = w_old + (CW+1)'(1);
        w_limit = $signed((CW+1)'({1'b0, r_first} + {1'b0, w_period}));
        if (r_down) begin
            w_new = (w_inc > w_limit) ? $signed((CW+1)'(r_first)) : w_inc;
        end else begin
            w_new = (w_old > 0) ? -(CW+1)'(1) : '0;
        end
    end

    always_comb begin
        w_rem_sh = {r_rem, r_dvd[DW-1]};
        w_rem_nx = (w_rem_sh >= {1'b0, w_period}) ? FW'(w_rem_sh - {1'b0, w_period})
                                                  : FW'(w_rem_sh);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(KEY_COUNT - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_in_range && (w_new > $signed((CW+1)'(r_first)))
                    && (w_new != (CW+1)'(1))) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == SW'(DW - 1)) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_first     <= kart_pkg::FIRST_DELAY_RST;
            r_period    <= kart_pkg::REPEAT_PERIOD_RST;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    kart_pkg::CFG_FIRST_DELAY:   r_first  <= i_cfg_data;
                    kart_pkg::CFG_REPEAT_PERIOD: r_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DIV) begin
                r_div_cnt <= r_div_cnt + SW'(1);
            end else begin
                r_div_cnt <= '0;
            end
        end
    end

    // counter store: clearing pass, write back, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_state == ST_CALC && r_in_range) begin
            r_mem[r_addr] <= CW'(w_new);
        end
        if (w_in_xfer) r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_addr     <= w_addr;
            r_key      <= i_in.key_index;
            r_down     <= i_in.key_down;
            r_in_range <= (32'(i_in.key_index) < KEY_COUNT);
        end
        if (r_state == ST_CALC) begin
            r_held     <= r_in_range && (w_new > 0);
            r_jp       <= r_in_range && (w_new == (CW+1)'(1));
            r_jr       <= r_in_range && (w_new == -(CW+1)'(1));
            r_fire     <= r_in_range && (w_new == (CW+1)'(1));
            r_need_div <= r_in_range && (w_new > $signed((CW+1)'(r_first)))
                          && (w_new != (CW+1)'(1));
            r_dvd      <= DW'(w_new);
            r_rem      <= '0;
        end else if (r_state == ST_DIV) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= w_rem_nx;
        end
        if (w_out_load) begin
            r_out.key_id        <= r_key;
            r_out.held          <= r_held;
            r_out.just_pressed  <= r_jp;
            r_out.just_released <= r_jr;
            r_out.repeat_fire   <= r_fire || (r_need_div && (r_rem == '0));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_CALC))
        else $error("accepted item did not enter update");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_div_cnt == SW'(DW - 1)) |=> (r_state == ST_FIN))
        else $error("remainder unit ran past dividend width");

    a_press_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.just_pressed) |-> (o_out.held && o_out.repeat_fire))
        else $error("new press without held and repeat");

    a_release_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.just_released) |-> (!o_out.held && !o_out.repeat_fire))
        else $error("release reported with held or repeat");

endmodule

[bench/key_auto_repeat_tracker_test.sv]
// ----------------------------------------------------------------------------
// key_auto_repeat_tracker_test: self-checking bench for the auto-repeat tracker
// Sends key frame samples through random input gaps and output stalls.
// A scoreboard keeps its own per-key hold counts and registers, predicts each
// result's flags and compares them field by field, in order. A short directed
// run covers:
//   - press, release and a press right after release
//   - the end keys
//   - a zero first delay
// Random phases follow under several register settings, the extremes among
// them. Most random frames are holds of one key of random length with noise
// frames in between.
// ----------------------------------------------------------------------------
module key_auto_repeat_tracker_test;

    localparam int KEYS         = 256;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_FRAMES = 70;
    localparam int KEY_W        = kart_pkg::KEY_W;
    localparam int CFG_W        = kart_pkg::CFG_W;

    class key_repeat_scoreboard;
        int                  first_delay;
        int                  repeat_period;
        int                  hold_count[KEYS];
        kart_pkg::t_out_item expected_q[$];
        int                  errors;
        int                  checked;
        int                  fires;

        function new();
            first_delay   = kart_pkg::FIRST_DELAY_RST;
            repeat_period = kart_pkg::REPEAT_PERIOD_RST;
            foreach (hold_count[k]) hold_count[k] = 0;
            errors  = 0;
            checked = 0;
            fires   = 0;
        endfunction

        function void set_reg(logic [kart_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == kart_pkg::CFG_FIRST_DELAY) begin
                first_delay = data;
            end else begin
                repeat_period = data;
            end
        endfunction

        function void note_frame(kart_pkg::t_in_item frame);
            int                  c;
            int                  p;
            kart_pkg::t_out_item e;
            p = (repeat_period == 0) ? 1 : repeat_period;
            c = hold_count[frame.key_index];
            if (frame.key_down) begin
                c = c + 1;
                if (c > first_delay + p) c = first_delay;
            end else begin
                c = (c > 0) ? -1 : 0;
            end
            hold_count[frame.key_index] = c;
            e.key_id        = frame.key_index;
            e.held          = (c > 0);
            e.just_pressed  = (c == 1);
            e.just_released = (c == -1);
            e.repeat_fire   = (c == 1) || (c > first_delay && (c % p) == 0);
            expected_q.push_back(e);
        endfunction

        function void check_result(kart_pkg::t_out_item got);
            kart_pkg::t_out_item e;
            if (expected_q.size() == 0) begin
                $error("result with no frame pending: key_id %0d", got.key_id);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.repeat_fire) fires++;
            if (got.key_id !== e.key_id) begin
                $error("key_id: expected %0d, got %0d", e.key_id, got.key_id);
                errors++;
            end
            if (got.held !== e.held) begin
                $error("held: expected %0b, got %0b", e.held, got.held);
                errors++;
            end
            if (got.just_pressed !== e.just_pressed) begin
                $error("just_pressed: expected %0b, got %0b", e.just_pressed,
                       got.just_pressed);
                errors++;
            end
            if (got.just_released !== e.just_released) begin
                $error("just_released: expected %0b, got %0b", e.just_released,
                       got.just_released);
                errors++;
            end
            if (got.repeat_fire !== e.repeat_fire) begin
                $error("repeat_fire: expected %0b, got %0b", e.repeat_fire,
                       got.repeat_fire);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    kart_pkg::t_in_item             in_frame;
    logic                           out_valid;
    logic                           out_ready;
    kart_pkg::t_out_item            out_item;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [kart_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]               cfg_data;

    key_repeat_scoreboard sb = new();

    bit in_calm        = 1'b0;
    bit out_calm       = 1'b0;
    int frames_sent    = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;

    key_auto_repeat_tracker #(
        .KEY_COUNT(KEYS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_frame),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic send_frame(logic [KEY_W-1:0] key, logic down);
        int                 gap;
        kart_pkg::t_in_item f;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        gap = draw_gap(in_calm);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        f.key_index = key;
        f.key_down  = down;
        in_frame <= f;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_frame(in_frame);
        frames_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_settings(int fd, int rp);
        cfg_index <= kart_pkg::CFG_FIRST_DELAY;
        cfg_data  <= CFG_W'(fd);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_reg(kart_pkg::CFG_FIRST_DELAY, CFG_W'(fd));
        cfg_index <= kart_pkg::CFG_REPEAT_PERIOD;
        cfg_data  <= CFG_W'(rp);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_reg(kart_pkg::CFG_REPEAT_PERIOD, CFG_W'(rp));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(int fd, int rp, int frames);
        logic [KEY_W-1:0] pool[6];
        logic [KEY_W-1:0] key_sel;
        int               target;
        int               hold;
        int               cap;
        int               rel;
        drain();
        write_settings(fd, rp);
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < 6; i++) pool[i] = KEY_W'($urandom_range(0, KEYS - 1));
        cap = fd + 2 * rp + 2;
        if (cap > 300) cap = 300;
        target = frames_sent + frames;
        while (frames_sent < target) begin
            key_sel = pool[$urandom_range(0, 5)];
            hold = $urandom_range(0, 1) ? $urandom_range(fd + rp, cap) : $urandom_range(1, 8);
            rel  = $urandom_range(0, 2);
            for (int n = 0; n < hold + rel; n++) begin
                if ($urandom_range(0, 5) == 0)
                    send_frame(KEY_W'($urandom_range(0, KEYS - 1)), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) == 0) drain();
                send_frame(key_sel, n < hold);
            end
        end
    endtask

    initial begin : result_sink
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
            gap = draw_gap(out_calm);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(out_item);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("key_auto_repeat_tracker_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_frame  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= kart_pkg::CFG_FIRST_DELAY;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // press, release, press right after release, end keys
        send_frame(8'd0, 1'b1);
        send_frame(8'd0, 1'b0);
        send_frame(8'd0, 1'b1);
        send_frame(8'd0, 1'b1);
        send_frame(8'd255, 1'b1);
        send_frame(8'd255, 1'b0);
        send_frame(8'd255, 1'b0);
        send_frame(8'd0, 1'b0);

        // zero first delay: wrap drops the count to zero while held
        drain();
        write_settings(0, 1);
        send_frame(8'h55, 1'b1);
        send_frame(8'h55, 1'b1);
        send_frame(8'h55, 1'b1);
        send_frame(8'hAA, 1'b1);
        send_frame(8'hAA, 1'b0);

        drain();
        write_settings(2, 3);
        repeat (8) send_frame(8'd1, 1'b1);
        send_frame(8'd1, 1'b0);

        random_phase(127, 127, PHASE_FRAMES);
        random_phase(127, 1, PHASE_FRAMES);
        random_phase(0, 127, PHASE_FRAMES);
        random_phase(1, 1, PHASE_FRAMES);
        random_phase(kart_pkg::FIRST_DELAY_RST, kart_pkg::REPEAT_PERIOD_RST, PHASE_FRAMES);
        random_phase($urandom_range(0, 40), $urandom_range(1, 24), PHASE_FRAMES);
        random_phase($urandom_range(0, 40), $urandom_range(1, 24), PHASE_FRAMES);

        drain();
        repeat (16) @(posedge clk);
        $display("covered %0d frames under %0d register settings; %0d results checked, %0d repeats",
                 frames_sent, settings_used, sb.checked, sb.fires);
        if (sb.errors == 0) begin
            $display("key_auto_repeat_tracker_test: clean");
        end else begin
            $display("key_auto_repeat_tracker_test: errors");
        end
        $finish;
    end

endmodule
